@@ design/jrl_pkg.sv @@
// Package for the joystick radial limiter: word types and shared constants.
package jrl_pkg;

    localparam int RAW_W            = 32;
    localparam int AXIS_W           = 16;
    localparam int SQ_W             = 31;
    localparam int SUM_W            = 32;
    localparam int LIM2_W           = 30;
    localparam int TGT_W            = 60;
    localparam int PROD_W           = 64;
    localparam int QACC_W           = 48;
    localparam int ITER_N           = 16;
    localparam int RADIUS_LIMIT_DEF = 32767;
    // clamp, square, sum/target, ITER_N search steps, output
    localparam int PIPE_DEPTH       = ITER_N + 4;

    localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sh7FFF;
    localparam logic signed [AXIS_W-1:0] AXIS_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [RAW_W-1:0] left_x_raw;
        logic signed [RAW_W-1:0] left_y_raw;
        logic signed [RAW_W-1:0] right_x_raw;
        logic signed [RAW_W-1:0] right_y_raw;
    } in_word_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] left_x_out;
        logic signed [AXIS_W-1:0] left_y_out;
        logic signed [AXIS_W-1:0] right_x_out;
        logic signed [AXIS_W-1:0] right_y_out;
    } out_word_t;

endpackage

@@ design/jrl_pair.sv @@
// Datapath for one stick pair: clamp, radius test and bit-per-stage scaled magnitude search.
module jrl_pair #(
    parameter int RADIUS_LIMIT = jrl_pkg::RADIUS_LIMIT_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [jrl_pkg::RAW_W-1:0]   x_raw,
    input  logic signed [jrl_pkg::RAW_W-1:0]   y_raw,
    output logic signed [jrl_pkg::AXIS_W-1:0]  x_out,
    output logic signed [jrl_pkg::AXIS_W-1:0]  y_out
);

    localparam int AW  = jrl_pkg::AXIS_W;
    localparam int NIT = jrl_pkg::ITER_N;
    localparam logic [jrl_pkg::LIM2_W-1:0] LIM2 =
        jrl_pkg::LIM2_W'(RADIUS_LIMIT * RADIUS_LIMIT);

    // stage 1: clamped axes and magnitudes
    logic signed [AW-1:0] c1_reg [2];
    logic        [AW-1:0] m1_reg [2];
    // stage 2: squares
    logic signed [AW-1:0] c2_reg [2];
    logic [jrl_pkg::SQ_W-1:0] sq2_reg [2];
    // search state, index 0 loaded by the sum/target stage
    logic signed [AW-1:0]        cs_reg  [0:NIT][2];
    logic [jrl_pkg::TGT_W-1:0]   tgt_reg [0:NIT][2];
    logic [jrl_pkg::PROD_W-1:0]  p_reg   [0:NIT][2];
    logic [jrl_pkg::QACC_W-1:0]  q_reg   [0:NIT][2];
    logic [AW-1:0]               n_reg   [0:NIT][2];
    logic [jrl_pkg::SUM_W-1:0]   s_reg   [0:NIT];
    logic                        big_reg [0:NIT];
    logic signed [AW-1:0]        o_reg   [2];

    logic signed [jrl_pkg::RAW_W-1:0] raw [2];
    logic signed [AW-1:0] clamp_next [2];
    logic        [AW-1:0] mag_next   [2];
    logic [jrl_pkg::SUM_W-1:0] sum_next;

    assign raw[0] = x_raw;
    assign raw[1] = y_raw;

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            if (raw[a] > jrl_pkg::RAW_W'(jrl_pkg::AXIS_MAX))
                clamp_next[a] = jrl_pkg::AXIS_MAX;
            else if (raw[a] < jrl_pkg::RAW_W'(jrl_pkg::AXIS_MIN))
                clamp_next[a] = jrl_pkg::AXIS_MIN;
            else
                clamp_next[a] = raw[a][AW-1:0];
            mag_next[a] = clamp_next[a][AW-1] ? AW'(-clamp_next[a]) : clamp_next[a];
        end
        sum_next = jrl_pkg::SUM_W'(sq2_reg[0]) + jrl_pkg::SUM_W'(sq2_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 2; a++)
            begin
                c1_reg[a]  <= clamp_next[a];
                m1_reg[a]  <= mag_next[a];
                c2_reg[a]  <= c1_reg[a];
                sq2_reg[a] <= jrl_pkg::SQ_W'(m1_reg[a] * m1_reg[a]);
                cs_reg[0][a]  <= c2_reg[a];
                tgt_reg[0][a] <= jrl_pkg::TGT_W'(sq2_reg[a] * LIM2);
                p_reg[0][a]   <= '0;
                q_reg[0][a]   <= '0;
                n_reg[0][a]   <= '0;
            end
            s_reg[0]   <= sum_next;
            big_reg[0] <= sum_next > jrl_pkg::SUM_W'(LIM2);
        end
    end

    // one result bit per stage, MSB first: try n | bit, keep it if n^2*S still fits
    for (genvar k = 0; k < NIT; k++)
    begin : g_step
        localparam int B = NIT - 1 - k;
        logic [jrl_pkg::PROD_W-1:0] cand [2];
        logic                       fit  [2];

        always_comb
        begin
            for (int a = 0; a < 2; a++)
            begin
                cand[a] = p_reg[k][a]
                        + (jrl_pkg::PROD_W'(q_reg[k][a]) << (B + 1))
                        + (jrl_pkg::PROD_W'(s_reg[k]) << (2 * B));
                fit[a]  = cand[a] <= jrl_pkg::PROD_W'(tgt_reg[k][a]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int a = 0; a < 2; a++)
                begin
                    cs_reg[k+1][a]  <= cs_reg[k][a];
                    tgt_reg[k+1][a] <= tgt_reg[k][a];
                    if (fit[a])
                    begin
                        p_reg[k+1][a] <= cand[a];
                        q_reg[k+1][a] <= q_reg[k][a]
                                       + (jrl_pkg::QACC_W'(s_reg[k]) << B);
                        n_reg[k+1][a] <= n_reg[k][a] | (AW'(1) << B);
                    end
                    else
                    begin
                        p_reg[k+1][a] <= p_reg[k][a];
                        q_reg[k+1][a] <= q_reg[k][a];
                        n_reg[k+1][a] <= n_reg[k][a];
                    end
                end
                s_reg[k+1]   <= s_reg[k];
                big_reg[k+1] <= big_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 2; a++)
            begin
                if (!big_reg[NIT])
                    o_reg[a] <= cs_reg[NIT][a];
                else if (cs_reg[NIT][a][AW-1])
                    o_reg[a] <= AW'(-n_reg[NIT][a]);
                else
                    o_reg[a] <= n_reg[NIT][a];
            end
        end
    end

    assign x_out = o_reg[0];
    assign y_out = o_reg[1];

endmodule

@@ design/joystick_radial_limiter.sv @@
// Top level of the joystick radial limiter: handshake control and the two pair datapaths.
// Throughput: one word per cycle while the output is not stalled; the 16-stage magnitude search sets the depth.
// The pipeline advances whenever the output register is empty or being taken.
// Reset clears the stage valid bits only; no word is in flight after reset.
module joystick_radial_limiter #(
    parameter int RADIUS_LIMIT = jrl_pkg::RADIUS_LIMIT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  jrl_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output jrl_pkg::out_word_t out_data
);

    localparam int DEPTH = jrl_pkg::PIPE_DEPTH;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             en;

    assign en        = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[DEPTH-1];

    always_comb
    begin
        vld_next = vld_reg;
        if (en)
            vld_next = {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    jrl_pair #(.RADIUS_LIMIT(RADIUS_LIMIT)) u_left (
        .clk   (clk),
        .en    (en),
        .x_raw (in_data.left_x_raw),
        .y_raw (in_data.left_y_raw),
        .x_out (out_data.left_x_out),
        .y_out (out_data.left_y_out)
    );

    jrl_pair #(.RADIUS_LIMIT(RADIUS_LIMIT)) u_right (
        .clk   (clk),
        .en    (en),
        .x_raw (in_data.right_x_raw),
        .y_raw (in_data.right_y_raw),
        .x_out (out_data.right_x_out),
        .y_out (out_data.right_y_out)
    );

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a blocked output");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted word not entered into pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("pending output word dropped");

    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.left_x_out != jrl_pkg::AXIS_MIN
                    && out_data.right_y_out != jrl_pkg::AXIS_MIN))
        else $error("full-scale negative axis escaped the radial limit");

endmodule
